/* hdl/ptw_pkg.sv */
// Shared types, codes and helpers for the four-level page table walker.
`default_nettype none
package ptw_pkg;

  localparam int EntriesPerTable = 512;
  localparam int IdxW            = 9;
  localparam int VaW             = 48;
  localparam int PaW             = 52;
  localparam int FrameW          = 40;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1
  } state_t;

  typedef logic [1:0] level_t;

  localparam level_t LVL_PT   = 2'd0;
  localparam level_t LVL_PD   = 2'd1;
  localparam level_t LVL_PDPT = 2'd2;
  localparam level_t LVL_PML4 = 2'd3;

  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  localparam logic [1:0] STATUS_MAPPED     = 2'd0;
  localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE    = 2'd2;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic REG_ROOT_TABLE = 1'b0;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  function automatic logic [IdxW-1:0] idx_of(logic [VaW-1:0] va, level_t level);
    logic [IdxW-1:0] idx;
    unique case (level)
      LVL_PT:   idx = va[20:12];
      LVL_PD:   idx = va[29:21];
      LVL_PDPT: idx = va[38:30];
      LVL_PML4: idx = va[47:39];
      default:  idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

/* hdl/ptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptw_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/four_level_page_table_walker_top.sv */
// Top level of the four-level page table walker.
//
// Input channel: an item is taken when start is high and busy is low.
// in_opcode write stores in_word_data at table word in_word_index (slots
// times 512 entries; indexes past the store are dropped). in_opcode translate
// walks PML4, PDPT, PD and PT for in_virt_addr starting at slot root_table.
// Result channel: out_strobe marks one cycle carrying out_status,
// out_page_size_code and out_phys_addr; the receiver cannot stall it.
// Results: a write gives its result in the cycle after it is taken and busy
// never rises. A translate reads one table word per cycle from the
// registered-read table RAM, one per level visited, then registers the
// result; a bad root answers in the cycle after it is taken. busy stays high
// for the walk, so one translate runs at a time.
// Config: APB port, register root_table at byte address 0; the user must
// write it only while idle (not enforced). Reset clears control state and
// root_table; table words are undefined until written, need no clearing pass.
`default_nettype none
module four_level_page_table_walker_top
  import ptw_pkg::*;
#(
  parameter int TABLE_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [11:0] in_word_index,
  input  wire logic [63:0] in_word_data,
  input  wire logic [47:0] in_virt_addr,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [1:0]       out_page_size_code,
  output logic [51:0]      out_phys_addr,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int StoreWords = TABLE_COUNT * EntriesPerTable;
  localparam int SlotW      = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int AddrW      = SlotW + IdxW;

  state_t state_r, state_nxt;
  level_t level_r, level_nxt;
  logic [VaW-1:0] va_r, va_nxt;
  logic [2:0] root_table_r;
  logic out_strobe_r, out_strobe_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [1:0] out_size_r, out_size_nxt;
  logic [PaW-1:0] out_pa_r, out_pa_nxt;

  logic accept;
  logic cfg_wr;
  logic [31:0] widx_ext;
  logic write_ok;
  logic [31:0] root_ext;
  logic root_ok;
  logic [SlotW-1:0] root_slot;
  logic ram_we;
  logic [AddrW-1:0] ram_raddr;
  logic [63:0] entry;
  logic present, page_size_bit;
  logic [FrameW-1:0] frame;
  logic frame_ok;
  logic walk_done;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_ROOT_TABLE) ? {29'd0, root_table_r} : 32'd0;

  assign widx_ext  = {20'd0, in_word_index};
  assign write_ok  = (widx_ext < 32'(StoreWords));
  assign root_ext  = {29'd0, root_table_r};
  assign root_ok   = (root_ext < 32'(TABLE_COUNT));
  assign root_slot = root_ext[SlotW-1:0];

  assign present       = entry[BIT_PRESENT];
  assign page_size_bit = entry[BIT_LARGE];
  assign frame         = entry[51:12];
  assign frame_ok      = (frame < FrameW'(TABLE_COUNT));
  assign walk_done     = !present || (level_r == LVL_PT) || !frame_ok ||
                         ((level_r == LVL_PDPT || level_r == LVL_PD) && page_size_bit);

  ptw_ram #(
    .WIDTH  (64),
    .DEPTH  (StoreWords),
    .ADDR_W (AddrW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_ext[AddrW-1:0]),
    .wdata (in_word_data),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_TRANSLATE && root_ok) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    level_nxt      = level_r;
    va_nxt         = va_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_size_nxt   = out_size_r;
    out_pa_nxt     = out_pa_r;
    ram_we         = 1'b0;
    ram_raddr      = {frame[SlotW-1:0], idx_of(va_r, level_r - 2'd1)};
    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = {root_slot, idx_of(in_virt_addr, LVL_PML4)};
        if (accept) begin
          if (in_opcode == OP_WRITE) begin
            ram_we         = write_ok;
            out_strobe_nxt = 1'b1;
            out_status_nxt = STATUS_MAPPED;
            out_size_nxt   = SIZE_4K;
            out_pa_nxt     = '0;
          end else begin
            va_nxt    = in_virt_addr;
            level_nxt = LVL_PML4;
            if (!root_ok) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = STATUS_OUTSIDE;
              out_size_nxt   = LVL_PML4;
              out_pa_nxt     = '0;
            end
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          out_strobe_nxt = 1'b1;
        end else begin
          level_nxt = level_r - 2'd1;
        end
        priority if (!present) begin
          out_status_nxt = STATUS_NOT_MAPPED;
          out_size_nxt   = level_r;
          out_pa_nxt     = '0;
        end else if (level_r == LVL_PDPT && page_size_bit) begin
          out_status_nxt = STATUS_MAPPED;
          out_size_nxt   = SIZE_1G;
          out_pa_nxt     = {entry[51:30], va_r[29:0]};
        end else if (level_r == LVL_PD && page_size_bit) begin
          out_status_nxt = STATUS_MAPPED;
          out_size_nxt   = SIZE_2M;
          out_pa_nxt     = {entry[51:21], va_r[20:0]};
        end else if (level_r == LVL_PT) begin
          out_status_nxt = STATUS_MAPPED;
          out_size_nxt   = SIZE_4K;
          out_pa_nxt     = {entry[51:12], va_r[11:0]};
        end else begin
          out_status_nxt = STATUS_OUTSIDE;
          out_size_nxt   = level_r - 2'd1;
          out_pa_nxt     = '0;
        end
      end
      default: begin
        level_nxt = level_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      root_table_r <= 3'd0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr && paddr[2] == REG_ROOT_TABLE) begin
        root_table_r <= pwdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r      <= level_nxt;
    va_r         <= va_nxt;
    out_status_r <= out_status_nxt;
    out_size_r   <= out_size_nxt;
    out_pa_r     <= out_pa_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_page_size_code = out_size_r;
  assign out_phys_addr      = out_pa_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while walk still busy");

  a_translate_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_TRANSLATE) |=> (busy || out_strobe))
    else $error("translate item neither walking nor answered");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_WRITE) |=>
      (out_strobe && out_status == STATUS_MAPPED && out_phys_addr == '0))
    else $error("write item result wrong");

  a_fail_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != STATUS_MAPPED) |-> (out_phys_addr == '0))
    else $error("failed walk reports nonzero address");

  a_level_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && !walk_done) |=> (level_r == $past(level_r) - 2'd1))
    else $error("walk level did not descend");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the four-level page table walker: table loads and walks.
`timescale 1ns / 1ps
module testbench;
  import ptw_pkg::*;

  localparam int TableCount = 8;
  localparam int StoreWords = TableCount * EntriesPerTable;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  size;
    logic [51:0] pa;
  } walk_result_t;

  class walk_scoreboard;
    logic [63:0]  table_copy [0:StoreWords-1];
    bit           written [0:StoreWords-1];
    logic [2:0]   root_slot;
    walk_result_t expected_q [$];
    int           mismatch_count;

    function new();
      for (int i = 0; i < StoreWords; i++) begin
        written[i] = 1'b0;
        table_copy[i] = '0;
      end
      root_slot = '0;
      mismatch_count = 0;
    endfunction

    function walk_result_t trace_walk(input logic [47:0] va, output int missing_word);
      walk_result_t r;
      logic [63:0]  e;
      logic [39:0]  slot;
      logic [8:0]   idx;
      int           w;
      missing_word = -1;
      r = '{STATUS_NOT_MAPPED, SIZE_4K, '0};
      slot = 40'(root_slot);
      for (int lvl = 3; lvl >= 0; lvl--) begin
        idx = va[12 + 9 * lvl +: 9];
        if (slot >= 40'(TableCount)) begin
          r = '{STATUS_OUTSIDE, 2'(lvl), '0};
          return r;
        end
        w = int'(slot) * EntriesPerTable + int'(idx);
        if (!written[w]) begin
          missing_word = w;
          return r;
        end
        e = table_copy[w];
        if (!e[BIT_PRESENT]) begin
          r = '{STATUS_NOT_MAPPED, 2'(lvl), '0};
          return r;
        end
        if (2'(lvl) == LVL_PDPT && e[BIT_LARGE]) begin
          r = '{STATUS_MAPPED, SIZE_1G, {e[51:30], va[29:0]}};
          return r;
        end
        if (2'(lvl) == LVL_PD && e[BIT_LARGE]) begin
          r = '{STATUS_MAPPED, SIZE_2M, {e[51:21], va[20:0]}};
          return r;
        end
        if (2'(lvl) == LVL_PT) begin
          r = '{STATUS_MAPPED, SIZE_4K, {e[51:12], va[11:0]}};
          return r;
        end
        slot = e[51:12];
      end
      return r;
    endfunction

    function void note_item(logic op, logic [11:0] widx, logic [63:0] wdata,
                            logic [47:0] va);
      walk_result_t r;
      int           miss;
      if (op == OP_WRITE) begin
        if (int'(widx) < StoreWords) begin
          table_copy[widx] = wdata;
          written[widx] = 1'b1;
        end
        r = '{STATUS_MAPPED, SIZE_4K, '0};
      end else begin
        r = trace_walk(va, miss);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [1:0] size, logic [51:0] pa);
      walk_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual status %0d size %0d pa %h",
                 $time, status, size, pa);
        mismatch_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
        mismatch_count++;
      end
      if (size !== exp_r.size) begin
        $display("%0t: page_size_code expected %0d actual %0d", $time, exp_r.size, size);
        mismatch_count++;
      end
      if (pa !== exp_r.pa) begin
        $display("%0t: phys_addr expected %h actual %h", $time, exp_r.pa, pa);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [11:0] in_word_index;
  logic [63:0] in_word_data;
  logic [47:0] in_virt_addr;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [1:0]  out_page_size_code;
  logic [51:0] out_phys_addr;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  walk_scoreboard sb;
  int             burst_left;

  four_level_page_table_walker_top #(
    .TABLE_COUNT(TableCount)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_word_index     (in_word_index),
    .in_word_data      (in_word_data),
    .in_virt_addr      (in_virt_addr),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_page_size_code(out_page_size_code),
    .out_phys_addr     (out_phys_addr),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result(out_status, out_page_size_code, out_phys_addr);
    end
  end

  function automatic logic [47:0] make_va(int i3, int i2, int i1, int i0, logic [11:0] off);
    return {9'(i3), 9'(i2), 9'(i1), 9'(i0), off};
  endfunction

  function automatic int pick_idx();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return 0;
      3:       return 1;
      4:       return 255;
      5, 6:    return 511;
      default: return $urandom_range(0, EntriesPerTable - 1);
    endcase
  endfunction

  function automatic logic [63:0] make_entry();
    logic [63:0] e;
    logic [39:0] frame;
    e = {$urandom, $urandom};
    if ($urandom_range(0, 15) < 13) frame = 40'($urandom_range(0, TableCount - 1));
    else frame = {8'($urandom), 32'($urandom)};
    e[51:12] = frame;
    e[BIT_PRESENT] = ($urandom_range(0, 9) != 0);
    e[BIT_LARGE] = ($urandom_range(0, 4) == 0);
    return e;
  endfunction

  task automatic send(input logic op, input logic [11:0] widx, input logic [63:0] wdata,
                      input logic [47:0] va);
    start <= 1'b1;
    in_opcode <= op;
    in_word_index <= widx;
    in_word_data <= wdata;
    in_virt_addr <= va;
    do @(posedge clk); while (busy);
    sb.note_item(op, widx, wdata, va);
  endtask

  task automatic load_word(input int slot, input int entry, input logic [63:0] data);
    send(OP_WRITE, 12'(slot * EntriesPerTable + entry), data, 48'({$urandom, $urandom}));
  endtask

  task automatic translate(input logic [47:0] va);
    send(OP_TRANSLATE, 12'($urandom), {$urandom, $urandom}, va);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    for (int k = 0; k < 2000 && sb.expected_q.size() > 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_root(input logic [2:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_ROOT_TABLE);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.root_slot = value;
  endtask

  task automatic run_random(input int count);
    int          r;
    int          miss;
    logic [47:0] va;
    walk_result_t probe;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send(OP_WRITE, 12'($urandom), {$urandom, $urandom}, 48'({$urandom, $urandom}));
      end else if (r < 22) begin
        load_word($urandom_range(0, TableCount - 1), pick_idx(), make_entry());
      end else begin
        va = make_va(pick_idx(), pick_idx(), pick_idx(), pick_idx(), 12'($urandom));
        probe = sb.trace_walk(va, miss);
        if (miss >= 0) send(OP_WRITE, 12'(miss), make_entry(), 48'({$urandom, $urandom}));
        else translate(va);
      end
      pace();
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= OP_WRITE;
    in_word_index <= '0;
    in_word_data <= '0;
    in_virt_addr <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_word(0, 0, 64'h0000_0000_0000_1001);
    load_word(1, 0, 64'h0000_0000_0000_2001);
    load_word(1, 1, 64'hFFFF_FFFF_C000_0081);
    load_word(2, 0, 64'h0000_0000_0000_3001);
    load_word(2, 1, 64'h800F_FFFF_FFE0_0081);
    load_word(3, 0, 64'hFFFF_FFFF_FFFF_F001);
    load_word(3, 511, 64'hFFFF_FFFF_FFFF_FFFE);
    load_word(0, 1, 64'h000F_FFFF_FFFF_F001);
    load_word(0, 2, 64'h0000_0000_0000_0000);
    load_word(0, 511, 64'h0000_0000_0000_1081);
    load_word(7, 511, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(make_va(0, 0, 0, 0, 12'hFFF));
    translate(make_va(0, 0, 0, 511, 12'h000));
    translate(make_va(0, 0, 1, 5, 12'hABC));
    translate(make_va(0, 1, 511, 511, 12'hFFF));
    translate(make_va(1, 0, 0, 0, 12'h000));
    translate(make_va(2, 511, 511, 511, 12'hFFF));
    translate(make_va(511, 0, 0, 0, 12'h123));
    pace();
    translate(make_va(511, 1, 511, 511, 12'hFFF));
    drain();

    write_root(3'd7);
    translate(make_va(511, 0, 0, 0, 12'h000));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_root(3'd0);
        1:       write_root(3'd7);
        default: write_root(3'($urandom_range(0, TableCount - 1)));
      endcase
      run_random(280);
      drain();
    end

    if (sb.expected_q.size() != 0) begin
      $display("%0t: missing items: expected %0d more, actual 0", $time, sb.expected_q.size());
      sb.mismatch_count++;
    end
    if (sb.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ptw_pkg.sv
hdl/ptw_ram.sv
hdl/four_level_page_table_walker_top.sv
tb/sv/testbench.sv
